// ===== rtl/msd_pkg.sv =====
// Shared constants, types and helper functions for the mask xor stream decryptor.
package msd_pkg;

    // Mask store geometry
    localparam int MASK_BYTES = 512;
    localparam int MASK_AW    = $clog2(MASK_BYTES);
    localparam int NB_W       = $clog2(MASK_BYTES + 1);
    localparam int LEN_W      = $clog2(MASK_BYTES / 2 + 1);

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Modulo unit
    localparam int SP_W   = 32;
    localparam int MOD_CW = $clog2(SP_W + 1);

    // Configuration port
    localparam int CFG_DW = 32;
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_MASK_LENGTH     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CRYPT_OFFSET    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_STREAM_POSITION = 3'd2;
    localparam logic [CFG_IW-1:0] REG_HEADER_LIMIT    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BUFFER_LENGTH   = 3'd4;

    // Byte constants
    localparam logic [7:0] CHK_SEED  = 8'hbb;
    localparam logic [7:0] HDR_FULL  = 8'h32;
    localparam logic [7:0] HDR_LIMIT = 8'h31;
    localparam logic [7:0] HDR_MARK  = 8'h55;

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_LIMIT = 2'd1,
        MODE_FULL  = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_BYTE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_HI,
        ST_SWEEP,
        ST_DISPATCH,
        ST_READ,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic [7:0]  mask_length;
        logic [15:0] crypt_offset;
        logic [31:0] stream_position;
        logic [31:0] header_limit;
        logic [15:0] buffer_length;
    } cfg_t;

    // One classified transaction in the queue
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic               last;
        mode_t              mode;
        logic               first;
        logic               hit;
        logic [MASK_AW-1:0] addr_lo;
        logic [MASK_AW-1:0] addr_hi;
    } entry_t;

    // Effective mask length: zero reads as one, clamp at half the store
    function automatic logic [LEN_W-1:0] eff_len(input logic [7:0] ml);
        logic [LEN_W-1:0] len;
        if (ml == 8'd0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(ml) > MASK_BYTES / 2)
        begin
            len = LEN_W'(MASK_BYTES / 2);
        end
        else
        begin
            len = LEN_W'(ml);
        end
        return len;
    endfunction

    // Number of mask bytes in use
    function automatic logic [NB_W-1:0] mask_bytes(input logic [7:0] ml);
        logic [LEN_W-1:0] len;
        len = eff_len(ml);
        return NB_W'({len, 1'b0});
    endfunction

endpackage

// ===== rtl/msd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/msd_fifo.sv =====
// Short queue of classified transactions between the front and back parts.
module msd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  msd_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output msd_pkg::entry_t head,
    output logic            head_valid
);

    msd_pkg::entry_t                  mem_reg [msd_pkg::Q_DEPTH];
    logic [msd_pkg::Q_AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [msd_pkg::Q_AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [msd_pkg::Q_CW-1:0]         count_reg, count_next;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == msd_pkg::Q_AW'(msd_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == msd_pkg::Q_AW'(msd_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full       = (count_reg == msd_pkg::Q_CW'(msd_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/msd_front.sv =====
// Front part: accepts transactions, tracks buffer position and mode, classifies bytes.
module msd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  msd_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            action,
    input  logic [7:0]      data_value,
    input  logic            last_in,
    input  logic            q_full,
    output logic            push,
    output msd_pkg::entry_t push_entry
);

    logic [7:0]          load_count_reg, load_count_next;
    logic [15:0]         byte_pos_reg, byte_pos_next;
    msd_pkg::mode_t      mode_reg, mode_next;

    logic [msd_pkg::LEN_W-1:0]   len;
    logic [msd_pkg::NB_W-1:0]    nb;
    logic [7:0]                  j_eff;
    logic [8:0]                  j_inc;
    logic [msd_pkg::NB_W-1:0]    hi_full;
    logic                        first;
    msd_pkg::mode_t              mode_first, mode_eff;
    logic [15:0]                 pos_rel;
    logic [31:0]                 bound;
    logic [32:0]                 reach;
    logic                        in_window;
    logic                        accept;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign push     = accept;

    // Mask load addresses: low byte at 2j, complement at 2L-1-2j
    always_comb
    begin
        len     = msd_pkg::eff_len(cfg.mask_length);
        nb      = msd_pkg::mask_bytes(cfg.mask_length);
        j_eff   = (32'(load_count_reg) >= 32'(len)) ? 8'd0 : load_count_reg;
        j_inc   = {1'b0, j_eff} + 9'd1;
        hi_full = nb - msd_pkg::NB_W'(1) - msd_pkg::NB_W'({j_eff, 1'b0});
    end

    // Byte classification: mode latch and decrypt window
    always_comb
    begin
        first = (byte_pos_reg == 16'd0);
        if (data_value == msd_pkg::HDR_FULL)
        begin
            mode_first = msd_pkg::MODE_FULL;
        end
        else if (data_value == msd_pkg::HDR_LIMIT)
        begin
            mode_first = msd_pkg::MODE_LIMIT;
        end
        else
        begin
            mode_first = msd_pkg::MODE_RAW;
        end
        mode_eff = first ? mode_first : mode_reg;
        bound    = (mode_eff == msd_pkg::MODE_FULL) ? {16'd0, cfg.buffer_length} :
                   cfg.header_limit;
        pos_rel  = byte_pos_reg - cfg.crypt_offset;
        reach    = {1'b0, cfg.stream_position} + {17'd0, pos_rel};
        // count = bound - stream_position, or one when bound does not exceed it
        if (byte_pos_reg < cfg.crypt_offset)
        begin
            in_window = 1'b0;
        end
        else if (bound > cfg.stream_position)
        begin
            in_window = (reach < {1'b0, bound});
        end
        else
        begin
            in_window = (pos_rel == 16'd0);
        end
    end

    // Queue entry
    always_comb
    begin
        push_entry.kind    = action ? msd_pkg::KIND_BYTE : msd_pkg::KIND_LOAD;
        push_entry.data    = data_value;
        push_entry.last    = last_in;
        push_entry.mode    = mode_eff;
        push_entry.first   = first;
        push_entry.hit     = (mode_eff != msd_pkg::MODE_RAW) && in_window;
        push_entry.addr_lo = msd_pkg::MASK_AW'({j_eff, 1'b0});
        push_entry.addr_hi = msd_pkg::MASK_AW'(hi_full);
    end

    // State update on accepted transactions
    always_comb
    begin
        load_count_next = load_count_reg;
        byte_pos_next   = byte_pos_reg;
        mode_next       = mode_reg;
        if (accept && !action)
        begin
            load_count_next = (32'(j_inc) >= 32'(len)) ? 8'd0 : j_inc[7:0];
        end
        if (accept && action)
        begin
            byte_pos_next = last_in ? 16'd0 : byte_pos_reg + 16'd1;
            mode_next     = mode_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= 8'd0;
            byte_pos_reg   <= 16'd0;
            mode_reg       <= msd_pkg::MODE_RAW;
        end
        else
        begin
            load_count_reg <= load_count_next;
            byte_pos_reg   <= byte_pos_next;
            mode_reg       <= mode_next;
        end
    end

endmodule

// ===== rtl/msd_mod.sv =====
// Bit-serial restoring modulo unit: stream position mod mask byte count.
module msd_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [msd_pkg::SP_W-1:0]    dividend,
    input  logic [msd_pkg::NB_W-1:0]    divisor,
    output logic                        busy,
    output logic [msd_pkg::NB_W-1:0]    rem
);

    logic                          busy_reg, busy_next;
    logic [msd_pkg::MOD_CW-1:0]    cnt_reg, cnt_next;
    logic [msd_pkg::SP_W-1:0]      dvd_reg, dvd_next;
    logic [msd_pkg::NB_W-1:0]      div_reg, div_next;
    logic [msd_pkg::NB_W-1:0]      rem_reg, rem_next;
    logic [msd_pkg::NB_W:0]        trial;

    // One quotient bit per cycle, MSB first
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[msd_pkg::SP_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = msd_pkg::MOD_CW'(msd_pkg::SP_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[msd_pkg::SP_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = msd_pkg::NB_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = msd_pkg::NB_W'(trial);
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == msd_pkg::MOD_CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/msd_back.sv =====
// Back part: mask store, checksum sweep, mask phase and output register.
module msd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  msd_pkg::cfg_t   cfg,
    input  msd_pkg::entry_t head,
    input  logic            head_valid,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic [1:0]      mode,
    output logic            last_out
);

    msd_pkg::back_state_t            state_reg, state_next;
    logic [msd_pkg::MASK_AW-1:0]     mask_index_reg, mask_index_next;
    logic [7:0]                      chk_reg, chk_next;
    logic [msd_pkg::NB_W-1:0]        sweep_cnt_reg, sweep_cnt_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic [7:0]                      res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    msd_pkg::mode_t                  out_mode_reg, out_mode_next;
    logic                            out_last_reg, out_last_next;

    logic                            ram_we, ram_re;
    logic [msd_pkg::MASK_AW-1:0]     ram_waddr, ram_raddr;
    logic [7:0]                      ram_wdata, ram_rdata;
    logic                            mod_start, mod_busy;
    logic [msd_pkg::NB_W-1:0]        mod_rem;

    logic [msd_pkg::NB_W-1:0]        nb;
    logic [msd_pkg::MASK_AW-1:0]     mi;
    logic [msd_pkg::NB_W-1:0]        mi_inc;
    logic [msd_pkg::MASK_AW-1:0]     mi_adv;
    logic                            out_free;
    logic                            sweep_done;
    logic [7:0]                      plain_res;

    msd_ram #(
        .WIDTH (8),
        .DEPTH (msd_pkg::MASK_BYTES)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msd_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cfg.stream_position),
        .divisor  (nb),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    // Mask phase with wrap, checksum sweep status
    always_comb
    begin
        nb         = msd_pkg::mask_bytes(cfg.mask_length);
        mi         = (msd_pkg::NB_W'(mask_index_reg) >= nb) ? '0 : mask_index_reg;
        mi_inc     = msd_pkg::NB_W'(mi) + msd_pkg::NB_W'(1);
        mi_adv     = (mi_inc >= nb) ? '0 : msd_pkg::MASK_AW'(mi_inc);
        out_free   = !out_valid_reg || !out_stall;
        sweep_done = (sweep_cnt_reg >= nb) && !rd_pend_reg && !mod_busy;
        // header byte of a processed buffer is overwritten
        plain_res  = (head.first && head.mode != msd_pkg::MODE_RAW) ?
                     msd_pkg::HDR_MARK : head.data;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.kind == msd_pkg::KIND_LOAD)
                    begin
                        state_next = msd_pkg::ST_LOAD_HI;
                    end
                    else if (head.first)
                    begin
                        state_next = msd_pkg::ST_SWEEP;
                    end
                    else if (head.hit)
                    begin
                        state_next = msd_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = msd_pkg::ST_EMIT;
                    end
                end
            end
            msd_pkg::ST_LOAD_HI:
            begin
                state_next = msd_pkg::ST_IDLE;
            end
            msd_pkg::ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = msd_pkg::ST_DISPATCH;
                end
            end
            msd_pkg::ST_DISPATCH:
            begin
                state_next = head.hit ? msd_pkg::ST_READ : msd_pkg::ST_EMIT;
            end
            msd_pkg::ST_READ:
            begin
                state_next = msd_pkg::ST_EMIT;
            end
            msd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = msd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = head.addr_lo;
        ram_wdata       = head.data;
        ram_re          = 1'b0;
        ram_raddr       = mi;
        pop             = 1'b0;
        mod_start       = 1'b0;
        mask_index_next = mask_index_reg;
        chk_next        = chk_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        rd_pend_next    = 1'b0;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        out_mode_next   = out_mode_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.kind == msd_pkg::KIND_LOAD)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (head.first)
                    begin
                        mod_start      = 1'b1;
                        chk_next       = msd_pkg::CHK_SEED;
                        sweep_cnt_next = '0;
                    end
                    else if (head.hit)
                    begin
                        ram_re = 1'b1;
                    end
                    else
                    begin
                        res_next = plain_res;
                    end
                end
            end
            msd_pkg::ST_LOAD_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = head.addr_hi;
                ram_wdata = ~head.data;
                pop       = 1'b1;
            end
            msd_pkg::ST_SWEEP:
            begin
                // issue one read per cycle, fold each returned byte in the cycle after its read
                if (sweep_cnt_reg < nb)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = msd_pkg::MASK_AW'(sweep_cnt_reg);
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                    rd_pend_next   = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    chk_next = {chk_reg[0], chk_reg[7:1]} ^ ram_rdata;
                end
                if (sweep_done)
                begin
                    mask_index_next = msd_pkg::MASK_AW'(mod_rem);
                end
            end
            msd_pkg::ST_DISPATCH:
            begin
                if (head.hit)
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    res_next = plain_res;
                end
            end
            msd_pkg::ST_READ:
            begin
                res_next        = head.first ? msd_pkg::HDR_MARK :
                                  (head.data ^ ram_rdata ^ chk_reg);
                mask_index_next = mi_adv;
            end
            msd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_reg;
                    out_mode_next  = head.mode;
                    out_last_next  = head.last;
                    pop            = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= msd_pkg::ST_IDLE;
            mask_index_reg <= '0;
            chk_reg        <= msd_pkg::CHK_SEED;
            sweep_cnt_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mask_index_reg <= mask_index_next;
            chk_reg        <= chk_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_byte_reg <= out_byte_next;
        out_mode_reg <= out_mode_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign mode      = out_mode_reg;
    assign last_out  = out_last_reg;

endmodule

// ===== rtl/mask_xor_stream_decryptor_core.sv =====
// Top level of the mask xor stream decryptor: configuration registers and part wiring.
//
// Input channel (in_valid / in_stall): action 0 loads the next mask character
// from data_value, action 1 sends the next buffer byte; last_in ends a buffer.
// Output channel (out_valid / out_stall): one transaction per buffer byte,
// carrying out_byte, mode and last_out; mask loads give no output.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index, idle only, a rule
// on the user that the block does not enforce. Timing: the front classifies a
// transaction in its accepting cycle and writes it to a four-entry queue; the back
// takes it from the next cycle. In the back, a mask load writes the low byte in IDLE
// and the complement in LOAD_HI (two writes through the single mask memory write
// port), a byte outside the decrypt window passes IDLE and EMIT, and a decrypted byte
// IDLE, READ and EMIT (registered mask read). The first byte of a buffer adds SWEEP
// and DISPATCH after IDLE: the checksum sweep reads the mask one byte a cycle while
// the position modulo runs alongside, and SWEEP waits for both.
// Reset clears the queue, positions, mode and mask phase and seeds the
// checksum with 0xbb; the mask memory is not cleared and must be loaded.
// While out_stall is high the result waits in the output register; the back
// part then stops and the queue fills until in_stall rises.
module mask_xor_stream_decryptor_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [7:0]                  data_value,
    input  logic                        last_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic [1:0]                  mode,
    output logic                        last_out,
    input  logic                        cfg_wr_en,
    input  logic [msd_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [msd_pkg::CFG_DW-1:0]  cfg_data
);

    msd_pkg::cfg_t      cfg_reg, cfg_next;
    msd_pkg::entry_t    push_entry, head;
    logic               push, q_full, pop, head_valid;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                msd_pkg::REG_MASK_LENGTH:     cfg_next.mask_length     = cfg_data[7:0];
                msd_pkg::REG_CRYPT_OFFSET:    cfg_next.crypt_offset    = cfg_data[15:0];
                msd_pkg::REG_STREAM_POSITION: cfg_next.stream_position = cfg_data[31:0];
                msd_pkg::REG_HEADER_LIMIT:    cfg_next.header_limit    = cfg_data[31:0];
                msd_pkg::REG_BUFFER_LENGTH:   cfg_next.buffer_length   = cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_length     <= 8'd1;
            cfg_reg.crypt_offset    <= 16'd0;
            cfg_reg.stream_position <= 32'd0;
            cfg_reg.header_limit    <= 32'd0;
            cfg_reg.buffer_length   <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    msd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .data_value (data_value),
        .last_in    (last_in),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    msd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    msd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .mode       (mode),
        .last_out   (last_out)
    );

endmodule

// ===== bench/msd_result_checker.sv =====
// Result checker for the mask xor stream decryptor: predicts every output transaction and compares.
`timescale 1ns / 1ps

module msd_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        action,
    input  logic [7:0]                  data_value,
    input  logic                        last_in,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [7:0]                  out_byte,
    input  logic [1:0]                  mode,
    input  logic                        last_out,
    input  logic                        cfg_wr_en,
    input  logic [msd_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [msd_pkg::CFG_DW-1:0]  cfg_data,
    output int                          fail_count,
    output int                          pending_results,
    output int                          checked_results
);

    // One predicted output transaction
    typedef struct packed {
        logic [7:0]     byte_v;
        msd_pkg::mode_t mode_v;
        logic           last_v;
    } decrypted_t;

    // Shadow of the block's registers and state
    msd_pkg::cfg_t   cfg_shadow;
    logic [7:0]      mask_mem [0:msd_pkg::MASK_BYTES-1];
    logic [7:0]      char_slot;
    logic [7:0]      mask_sum;
    logic [15:0]     buf_pos;
    msd_pkg::mode_t  buf_mode;
    int unsigned     mask_phase;
    decrypted_t      expected_bytes [$];

    // Mask length in use: zero reads as one, clamp at half the store
    function automatic int unsigned live_mask_len();
        int unsigned len;
        len = cfg_shadow.mask_length;
        if (len == 0)
        begin
            len = 1;
        end
        if (len > msd_pkg::MASK_BYTES / 2)
        begin
            len = msd_pkg::MASK_BYTES / 2;
        end
        return len;
    endfunction

    // Advance the shadow state by one input transaction, queue its result if any
    task automatic predict_transaction(input logic act, input logic [7:0] data,
                                       input logic last);
        int unsigned     len;
        int unsigned     nbytes;
        int unsigned     slot;
        int unsigned     n;
        longint unsigned bound;
        longint unsigned span;
        longint unsigned pos;
        logic [7:0]      sum;
        logic [7:0]      result;
        decrypted_t      exp_r;
        len    = live_mask_len();
        nbytes = 2 * len;

        // Mask character load: byte at 2j, complement mirrored from the top
        if (act == msd_pkg::KIND_LOAD)
        begin
            slot = char_slot;
            if (slot >= len)
            begin
                slot = 0;
            end
            mask_mem[2 * slot] = data;
            mask_mem[nbytes - 1 - 2 * slot] = ~data;
            slot++;
            if (slot >= len)
            begin
                slot = 0;
            end
            char_slot = slot[7:0];
            return;
        end

        // First byte: latch mode, checksum and starting mask phase
        if (buf_pos == 16'd0)
        begin
            if (data == msd_pkg::HDR_FULL)
            begin
                buf_mode = msd_pkg::MODE_FULL;
            end
            else if (data == msd_pkg::HDR_LIMIT)
            begin
                buf_mode = msd_pkg::MODE_LIMIT;
            end
            else
            begin
                buf_mode = msd_pkg::MODE_RAW;
            end
            sum = msd_pkg::CHK_SEED;
            for (n = 0; n < nbytes; n++)
            begin
                sum = {sum[0], sum[7:1]} ^ mask_mem[n];
            end
            mask_sum   = sum;
            mask_phase = cfg_shadow.stream_position % nbytes;
        end

        // Decrypt window, then mark the first byte
        result = data;
        if (buf_mode != msd_pkg::MODE_RAW)
        begin
            bound = (buf_mode == msd_pkg::MODE_FULL) ? longint'(cfg_shadow.buffer_length)
                                                     : longint'(cfg_shadow.header_limit);
            span  = (bound > cfg_shadow.stream_position)
                    ? bound - cfg_shadow.stream_position : 1;
            pos   = buf_pos;
            if (pos >= cfg_shadow.crypt_offset && pos - cfg_shadow.crypt_offset < span)
            begin
                if (mask_phase >= nbytes)
                begin
                    mask_phase = 0;
                end
                result = data ^ mask_mem[mask_phase] ^ mask_sum;
                mask_phase++;
                if (mask_phase >= nbytes)
                begin
                    mask_phase = 0;
                end
            end
            if (buf_pos == 16'd0)
            begin
                result = msd_pkg::HDR_MARK;
            end
        end

        exp_r.byte_v = result;
        exp_r.mode_v = buf_mode;
        exp_r.last_v = last;
        expected_bytes.push_back(exp_r);
        buf_pos = last ? 16'd0 : buf_pos + 16'd1;
    endtask

    // Compare one output transaction with the oldest prediction
    task automatic check_result();
        decrypted_t exp_r;
        if (expected_bytes.size() == 0)
        begin
            $error("unexpected transaction: out_byte %02h mode %0d last_out %0b",
                   out_byte, mode, last_out);
            fail_count++;
            return;
        end
        exp_r = expected_bytes.pop_front();
        checked_results++;
        if (out_byte !== exp_r.byte_v)
        begin
            $error("out_byte mismatch: expected %02h, actual %02h", exp_r.byte_v, out_byte);
            fail_count++;
        end
        if (mode !== exp_r.mode_v)
        begin
            $error("mode mismatch: expected %0d, actual %0d", exp_r.mode_v, mode);
            fail_count++;
        end
        if (last_out !== exp_r.last_v)
        begin
            $error("last_out mismatch: expected %0b, actual %0b", exp_r.last_v, last_out);
            fail_count++;
        end
    endtask

    // Watch the config port and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_shadow                 = '0;
            cfg_shadow.mask_length     = 8'd1;
            cfg_shadow.buffer_length   = 16'd1;
            char_slot                  = 8'd0;
            mask_sum                   = msd_pkg::CHK_SEED;
            buf_pos                    = 16'd0;
            buf_mode                   = msd_pkg::MODE_RAW;
            mask_phase                 = 0;
            expected_bytes.delete();
            fail_count                 = 0;
            pending_results            = 0;
            checked_results            = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    msd_pkg::REG_MASK_LENGTH:
                        cfg_shadow.mask_length     = cfg_data[7:0];
                    msd_pkg::REG_CRYPT_OFFSET:
                        cfg_shadow.crypt_offset    = cfg_data[15:0];
                    msd_pkg::REG_STREAM_POSITION:
                        cfg_shadow.stream_position = cfg_data[31:0];
                    msd_pkg::REG_HEADER_LIMIT:
                        cfg_shadow.header_limit    = cfg_data[31:0];
                    msd_pkg::REG_BUFFER_LENGTH:
                        cfg_shadow.buffer_length   = cfg_data[15:0];
                    default:             ;
                endcase
            end
            // compare before predicting so a same-edge input cannot match itself
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (in_valid && !in_stall)
            begin
                predict_transaction(action, data_value, last_in);
            end
            pending_results = expected_bytes.size();
        end
    end

endmodule

// ===== bench/tb_mask_xor_stream_decryptor_core.sv =====
// Testbench top for the mask xor stream decryptor core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_mask_xor_stream_decryptor_core;

    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 8;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         action     = 1'b0;
    logic [7:0]                   data_value = 8'd0;
    logic                         last_in    = 1'b0;
    logic                         out_stall  = 1'b0;
    logic                         cfg_wr_en  = 1'b0;
    logic [msd_pkg::CFG_IW-1:0]   cfg_index  = '0;
    logic [msd_pkg::CFG_DW-1:0]   cfg_data   = '0;
    logic                         in_stall;
    logic                         out_valid;
    logic [7:0]                   out_byte;
    logic [1:0]                   mode;
    logic                         last_out;

    int fail_count;
    int pending_results;
    int checked_results;

    // Idling rates in percent per transaction/cycle, set per phase
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int stall_run    = 0;

    // Run statistics
    int items_sent  = 0;
    int mask_loads  = 0;
    int full_bufs   = 0;
    int limit_bufs  = 0;
    int raw_bufs    = 0;
    int phase_count = 0;

    always #1 clk = ~clk;

    mask_xor_stream_decryptor_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .data_value (data_value),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .mode       (mode),
        .last_out   (last_out),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    msd_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .data_value      (data_value),
        .last_in         (last_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .mode            (mode),
        .last_out        (last_out),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .checked_results (checked_results)
    );

    // Receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct)
        begin
            stall_run <= $urandom_range(5, 0);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // One register write; the enable drops at the next edge
    task automatic write_reg(input logic [msd_pkg::CFG_IW-1:0] idx,
                             input logic [msd_pkg::CFG_DW-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Send one input transaction and wait for it to be taken
    task automatic send_item(input msd_pkg::kind_t kind, input logic [7:0] data,
                             input logic last);
        int gap;
        if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct)
        begin
            gap = $urandom_range(6, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= kind;
        data_value <= data;
        last_in    <= last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (kind == msd_pkg::KIND_LOAD)
        begin
            mask_loads++;
        end
    endtask

    // Hold the sender until every result is back and loads have drained
    task automatic drain();
        in_valid <= 1'b0;
        // let the checker count the last transaction taken before polling
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write every register, then fill the whole mask for the new length
    task automatic program_phase(input logic [7:0] len, input logic [15:0] off,
                                 input logic [31:0] sp, input logic [31:0] hl,
                                 input logic [15:0] bl);
        int chars;
        int k;
        write_reg(msd_pkg::REG_MASK_LENGTH, msd_pkg::CFG_DW'(len));
        write_reg(msd_pkg::REG_CRYPT_OFFSET, msd_pkg::CFG_DW'(off));
        write_reg(msd_pkg::REG_STREAM_POSITION, msd_pkg::CFG_DW'(sp));
        write_reg(msd_pkg::REG_HEADER_LIMIT, msd_pkg::CFG_DW'(hl));
        write_reg(msd_pkg::REG_BUFFER_LENGTH, msd_pkg::CFG_DW'(bl));
        chars = (len == 8'd0) ? 1 : int'(len);
        for (k = 0; k < chars; k++)
        begin
            send_item(msd_pkg::KIND_LOAD, 8'($urandom), 1'($urandom));
        end
        phase_count++;
    endtask

    // One buffer: header byte, random body, occasional mask loads in between
    task automatic send_buffer(input logic [7:0] hdr, input int blen);
        int k;
        if (hdr == msd_pkg::HDR_FULL)
        begin
            full_bufs++;
        end
        else if (hdr == msd_pkg::HDR_LIMIT)
        begin
            limit_bufs++;
        end
        else
        begin
            raw_bufs++;
        end
        for (k = 0; k < blen; k++)
        begin
            if (k > 0 && $urandom_range(99, 0) < 6)
            begin
                send_item(msd_pkg::KIND_LOAD, 8'($urandom), 1'($urandom));
            end
            send_item(msd_pkg::KIND_BYTE, (k == 0) ? hdr : 8'($urandom), k == blen - 1);
        end
    endtask

    // Stimulus
    initial
    begin
        int          p;
        int          start_items;
        int          blen;
        bit          paused;
        logic [7:0]  hdr;
        logic [7:0]  len_v;
        logic [15:0] off_v;
        logic [31:0] sp_v;
        logic [31:0] hl_v;
        logic [15:0] bl_v;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operation at the byte extremes, extra loads wrapping
        send_gap_pct = 20;
        stall_pct    = 20;
        program_phase(8'd2, 16'd1, 32'd1, 32'd3, 16'd4);
        send_item(msd_pkg::KIND_LOAD, 8'h00, 1'b0);
        send_item(msd_pkg::KIND_LOAD, 8'hff, 1'b1);
        send_item(msd_pkg::KIND_LOAD, 8'ha5, 1'b0);
        send_item(msd_pkg::KIND_BYTE, msd_pkg::HDR_FULL, 1'b0);
        send_item(msd_pkg::KIND_BYTE, 8'h80, 1'b0);
        send_item(msd_pkg::KIND_BYTE, 8'h7f, 1'b0);
        send_item(msd_pkg::KIND_BYTE, 8'hff, 1'b1);
        send_item(msd_pkg::KIND_BYTE, msd_pkg::HDR_LIMIT, 1'b0);
        send_item(msd_pkg::KIND_BYTE, 8'h00, 1'b0);
        send_item(msd_pkg::KIND_BYTE, 8'h01, 1'b1);
        send_item(msd_pkg::KIND_BYTE, 8'h00, 1'b0);
        send_item(msd_pkg::KIND_BYTE, 8'hff, 1'b1);
        send_item(msd_pkg::KIND_BYTE, msd_pkg::HDR_FULL, 1'b1);
        full_bufs  += 2;
        limit_bufs += 1;
        raw_bufs   += 1;
        drain();

        // Zero length reads as one; position past the bound leaves one byte
        program_phase(8'd0, 16'd0, 32'hffff_ffff, 32'd0, 16'd1);
        send_buffer(msd_pkg::HDR_LIMIT, 3);
        drain();

        // Leave the character index past a later, shorter length
        program_phase(8'd3, 16'd0, 32'd5, 32'd9, 16'd8);
        send_item(msd_pkg::KIND_LOAD, 8'h3c, 1'b0);
        send_item(msd_pkg::KIND_LOAD, 8'hc3, 1'b0);
        send_buffer(msd_pkg::HDR_FULL, 4);
        drain();
        program_phase(8'd1, 16'd2, 32'd0, 32'd4, 16'd6);
        send_buffer(msd_pkg::HDR_FULL, 5);
        drain();

        // Random phases, each with fresh settings and idling
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(5, 0))
                0:       len_v = 8'd0;
                1:       len_v = 8'd1;
                2:       len_v = 8'd255;
                3:       len_v = 8'($urandom_range(255, 1));
                default: len_v = 8'($urandom_range(12, 1));
            endcase
            case ($urandom_range(4, 0))
                0:       off_v = 16'd0;
                1:       off_v = 16'hffff;
                default: off_v = 16'($urandom_range(6, 0));
            endcase
            case ($urandom_range(4, 0))
                0:       sp_v = 32'd0;
                1:       sp_v = 32'hffff_ffff;
                2:       sp_v = $urandom;
                default: sp_v = $urandom_range(40, 0);
            endcase
            case ($urandom_range(4, 0))
                0:       hl_v = 32'd0;
                1:       hl_v = 32'hffff_ffff;
                default: hl_v = sp_v + $urandom_range(14, 0);
            endcase
            case ($urandom_range(4, 0))
                0:       bl_v = 16'd1;
                1:       bl_v = 16'hffff;
                default: bl_v = 16'(sp_v + $urandom_range(14, 1));
            endcase
            if (p == RANDOM_PHASES - 1)
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            else
            begin
                send_gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : 40;
                stall_pct    = $urandom_range(2, 0) * 20;
            end

            program_phase(len_v, off_v, sp_v, hl_v, bl_v);
            start_items = items_sent;
            paused      = 1'b0;
            while (items_sent - start_items < PHASE_ITEMS)
            begin
                case ($urandom_range(19, 0)) inside
                    [0:7]:   hdr = msd_pkg::HDR_FULL;
                    [8:14]:  hdr = msd_pkg::HDR_LIMIT;
                    default: hdr = 8'($urandom);
                endcase
                blen = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17)
                                                   : $urandom_range(16, 1);
                send_buffer(hdr, blen);
                // in phase three only, the sender waits once mid-phase for the output side to empty
                if (p == 3 && !paused && items_sent - start_items >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        $display("Covered %0d setting phases: %0d transactions sent, %0d mask loads,",
                 phase_count, items_sent, mask_loads);
        $display("%0d full, %0d limited and %0d raw buffers, %0d results checked.",
                 full_bufs, limit_bufs, raw_bufs, checked_results);
        if (fail_count == 0)
        begin
            $display("tb_mask_xor_stream_decryptor_core passed");
        end
        else
        begin
            $display("tb_mask_xor_stream_decryptor_core failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("tb_mask_xor_stream_decryptor_core failed");
        $finish;
    end

endmodule
